// ----- rtl/frustum_cull_test_defines.svh -----
// ============================================================================
// Frustum cull test assertion macros
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ============================================================================
`ifndef FRUSTUM_CULL_TEST_DEFINES_SVH
`define FRUSTUM_CULL_TEST_DEFINES_SVH

// Implication within the same cycle.
`define FCT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Antecedent followed by a consequent in the next cycle.
`define FCT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);

`endif

// ----- rtl/fct_pkg.sv -----
// ============================================================================
// Frustum cull test package
// Widths, request codes and the types shared by the frustum cull modules.
// ============================================================================
package fct_pkg;

	localparam int PLANES         = 6;
	localparam int NUM_PLANE_REGS = 6;
	localparam int COORD_W        = 16;
	localparam int COEF_W         = 16;
	localparam int RADIUS_W       = 15;
	localparam int FRAC_ALIGN     = 14;
	localparam int PROD_W         = COEF_W + COORD_W;
	localparam int SUM_W          = PROD_W + 2;
	localparam int CFG_W          = 4 * COEF_W;
	localparam int CFG_IDX_W      = 3;

	localparam logic REQ_SPHERE = 1'b0;
	localparam logic REQ_CORNER = 1'b1;

	typedef struct packed {
		logic signed [COEF_W-1:0] d;
		logic signed [COEF_W-1:0] c;
		logic signed [COEF_W-1:0] b;
		logic signed [COEF_W-1:0] a;
	} coef_t;

	typedef coef_t [PLANES-1:0] plane_arr_t;

	typedef struct packed {
		logic signed [PROD_W-1:0] pa;
		logic signed [PROD_W-1:0] pb;
		logic signed [PROD_W-1:0] pc;
		logic signed [COEF_W-1:0] d;
	} lane_t;

	typedef struct packed {
		logic                  vld;
		logic                  req_type;
		logic                  last_corner;
		logic [RADIUS_W-1:0]   radius;
		lane_t [PLANES-1:0]    lane;
	} s1_t;

endpackage

// ----- rtl/fct_if.sv -----
// ============================================================================
// Frustum cull test channels
// Request channel carrying one sphere or box corner, and response channel.
// ============================================================================
interface fct_req_if;
	logic                                valid;
	logic                                ready;
	logic                                req_type;
	logic signed [fct_pkg::COORD_W-1:0]  pos_x;
	logic signed [fct_pkg::COORD_W-1:0]  pos_y;
	logic signed [fct_pkg::COORD_W-1:0]  pos_z;
	logic [fct_pkg::RADIUS_W-1:0]        radius;
	logic                                last_corner;

	modport source(output valid, req_type, pos_x, pos_y, pos_z, radius, last_corner,
		input ready);
	modport sink(input valid, req_type, pos_x, pos_y, pos_z, radius, last_corner,
		output ready);
endinterface

interface fct_rsp_if;
	logic valid;
	logic ready;
	logic visible;

	modport source(output valid, visible, input ready);
	modport sink(input valid, visible, output ready);
endinterface

// ----- rtl/frustum_cull_test.sv -----
// ============================================================================
// Frustum cull test
// Tests spheres and box corner runs against the configured frustum planes.
// ============================================================================
//  Channel | Direction | Carries
//  req     | in        | req_type, pos_x, pos_y, pos_z, radius, last_corner
//  rsp     | out       | visible, one per sphere and one per last corner
//  cfg     | in        | plane write: cfg_we, cfg_idx, cfg_data
//
// A request is taken every cycle unless a stalled response holds stage 1.
// Stage 1 registers the eighteen coefficient products, stage 2 sums,
// compares and updates the corner mask into the response register.
// A stalled response holds both stages; reset clears the mask and planes.

module frustum_cull_test (
	input  logic                             clk,
	input  logic                             arst_n,
	fct_req_if.sink                          req,
	fct_rsp_if.source                        rsp,
	input  logic                             cfg_we,
	input  logic [fct_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fct_pkg::CFG_W-1:0]        cfg_data
);

	fct_pkg::plane_arr_t planes;
	fct_pkg::s1_t        s1;
	logic                adv;
	logic                req_acc;

	assign req.ready = !s1.vld || adv;
	assign req_acc   = req.valid && req.ready;

	fct_plane_regs u_regs (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.planes   (planes)
	);

	fct_mul_stage u_mul (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (req_acc),
		.drain       (adv),
		.req_type    (req.req_type),
		.pos_x       (req.pos_x),
		.pos_y       (req.pos_y),
		.pos_z       (req.pos_z),
		.radius      (req.radius),
		.last_corner (req.last_corner),
		.planes      (planes),
		.s1          (s1)
	);

	fct_eval u_eval (
		.clk       (clk),
		.arst_n    (arst_n),
		.s1        (s1),
		.rsp_ready (rsp.ready),
		.adv       (adv),
		.rsp_valid (rsp.valid),
		.visible   (rsp.visible)
	);

endmodule

// ----- rtl/fct_plane_regs.sv -----
// ============================================================================
// Frustum cull plane registers
// Holds the packed coefficients of each configured plane.
// ============================================================================
module fct_plane_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [fct_pkg::CFG_IDX_W-1:0]    cfg_idx,
	input  logic [fct_pkg::CFG_W-1:0]        cfg_data,
	output fct_pkg::plane_arr_t              planes
);

	for (genvar p = 0; p < fct_pkg::PLANES; p++) begin : g_plane
		if (p < fct_pkg::NUM_PLANE_REGS) begin : g_reg
			fct_pkg::coef_t plane_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					plane_q <= '0;
				end else if (cfg_we && cfg_idx == fct_pkg::CFG_IDX_W'(p)) begin
					plane_q <= fct_pkg::coef_t'(cfg_data);
				end
			end

			assign planes[p] = plane_q;
		end else begin : g_zero
			// Planes without a register read as all-zero coefficients.
			assign planes[p] = '0;
		end
	end

endmodule

// ----- rtl/fct_mul_stage.sv -----
// ============================================================================
// Frustum cull multiply stage
// Forms the three coefficient products of every plane into the stage 1 register.
// ============================================================================
module fct_mul_stage (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                load,
	input  logic                                drain,
	input  logic                                req_type,
	input  logic signed [fct_pkg::COORD_W-1:0]  pos_x,
	input  logic signed [fct_pkg::COORD_W-1:0]  pos_y,
	input  logic signed [fct_pkg::COORD_W-1:0]  pos_z,
	input  logic [fct_pkg::RADIUS_W-1:0]        radius,
	input  logic                                last_corner,
	input  fct_pkg::plane_arr_t                 planes,
	output fct_pkg::s1_t                        s1
);

	logic                                vld_s1;
	logic                                req_type_s1;
	logic                                last_s1;
	logic [fct_pkg::RADIUS_W-1:0]        radius_s1;
	fct_pkg::lane_t [fct_pkg::PLANES-1:0] lane_s1;
	fct_pkg::lane_t [fct_pkg::PLANES-1:0] lane_d;

	always_comb begin
		for (int p = 0; p < fct_pkg::PLANES; p++) begin
			lane_d[p].pa = fct_pkg::PROD_W'(planes[p].a) * fct_pkg::PROD_W'(pos_x);
			lane_d[p].pb = fct_pkg::PROD_W'(planes[p].b) * fct_pkg::PROD_W'(pos_y);
			lane_d[p].pc = fct_pkg::PROD_W'(planes[p].c) * fct_pkg::PROD_W'(pos_z);
			lane_d[p].d  = planes[p].d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (load) begin
			vld_s1 <= 1'b1;
		end else if (drain) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			req_type_s1 <= req_type;
			last_s1     <= last_corner;
			radius_s1   <= radius;
			lane_s1     <= lane_d;
		end
	end

	assign s1.vld         = vld_s1;
	assign s1.req_type    = req_type_s1;
	assign s1.last_corner = last_s1;
	assign s1.radius      = radius_s1;
	assign s1.lane        = lane_s1;

endmodule

// ----- rtl/fct_eval.sv -----
// ============================================================================
// Frustum cull evaluation stage
// Sums the plane values, tests spheres and box corners, and holds the result.
// ============================================================================
module fct_eval (
	input  logic          clk,
	input  logic          arst_n,
	input  fct_pkg::s1_t  s1,
	input  logic          rsp_ready,
	output logic          adv,
	output logic          rsp_valid,
	output logic          visible
);

	logic signed [fct_pkg::SUM_W-1:0] sum [fct_pkg::PLANES];
	logic signed [fct_pkg::SUM_W-1:0] r_ext;
	logic signed [fct_pkg::SUM_W-1:0] neg_r;
	logic [fct_pkg::PLANES-1:0]       outside;
	logic [fct_pkg::PLANES-1:0]       hit;
	logic [fct_pkg::PLANES-1:0]       mask_next;
	logic [fct_pkg::PLANES-1:0]       mask_q;
	logic                             is_sphere;
	logic                             gives_rsp;
	logic                             rsp_valid_q;
	logic                             visible_q;

	assign r_ext = {{(fct_pkg::SUM_W - fct_pkg::RADIUS_W - fct_pkg::FRAC_ALIGN){1'b0}},
		s1.radius, {fct_pkg::FRAC_ALIGN{1'b0}}};
	assign neg_r = -r_ext;

	always_comb begin
		for (int p = 0; p < fct_pkg::PLANES; p++) begin
			sum[p] = fct_pkg::SUM_W'(s1.lane[p].pa) + fct_pkg::SUM_W'(s1.lane[p].pb)
				+ fct_pkg::SUM_W'(s1.lane[p].pc)
				+ (fct_pkg::SUM_W'(s1.lane[p].d) <<< fct_pkg::FRAC_ALIGN);
			outside[p] = (sum[p] <= neg_r);
			hit[p]     = !sum[p][fct_pkg::SUM_W-1] && (|sum[p]);
		end
	end

	assign mask_next = mask_q | hit;
	assign is_sphere = (s1.req_type == fct_pkg::REQ_SPHERE);
	assign gives_rsp = s1.vld && (is_sphere || s1.last_corner);
	assign adv       = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= gives_rsp;
			if (s1.vld && !is_sphere) begin
				mask_q <= s1.last_corner ? '0 : mask_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && gives_rsp) begin
			visible_q <= is_sphere ? !(|outside) : (&mask_next);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign visible   = visible_q;

endmodule

// ----- rtl/fct_checker.sv -----
// ============================================================================
// Frustum cull test checker
// Port-level checks on the request and response channels.
// ============================================================================
`include "frustum_cull_test_defines.svh"

module fct_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic visible
);

	`FCT_ASSERT_NEXT(a_rsp_hold, out_valid && !out_ready, out_valid && $stable(visible), "response changed while stalled")
	`FCT_ASSERT(a_ready_when_free, !out_valid |-> in_ready, "request refused with empty response register")
	`FCT_ASSERT_NEXT(a_quiet, (!(in_valid && in_ready) && !out_valid) ##1 (!(in_valid && in_ready) && !out_valid), !out_valid, "response without a request")

endmodule

bind frustum_cull_test fct_checker u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (req.valid),
	.in_ready  (req.ready),
	.out_valid (rsp.valid),
	.out_ready (rsp.ready),
	.visible   (rsp.visible)
);
